@@ hw/rtl/b64enc_pkg.sv @@
// ----------------------------------------------------------------------------
// b64enc_pkg
// shared types, constants and the base64 alphabet lookup
// ----------------------------------------------------------------------------
package b64enc_pkg;

	localparam int CharW = 7;
	localparam int SlotN = 4;

	localparam logic [CharW-1:0] PAD_CHAR = 7'h3D;

	typedef logic [CharW-1:0] char_t;

	typedef struct packed {
		char_t [SlotN-1:0] chars;
		logic [1:0]        last_idx;
		logic              last_flag;
	} job_t;

	function automatic char_t enc_sextet(input logic [5:0] v);
		char_t c;
		c = char_t'(v);
		priority if (v < 6'd26) begin
			return c + 7'd65;
		end else if (v < 6'd52) begin
			return c + 7'd71;
		end else if (v < 6'd62) begin
			return c - 7'd4;
		end else if (v == 6'd62) begin
			return 7'h2B;
		end else begin
			return 7'h2F;
		end
	endfunction

endpackage

@@ hw/rtl/b64enc_front.sv @@
// ----------------------------------------------------------------------------
// b64enc_front
// takes raw bytes, tracks the group position and builds a character job
// ----------------------------------------------------------------------------
module b64enc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic               q_full,
	output logic               push,
	output b64enc_pkg::job_t   job
);
	import b64enc_pkg::*;

	localparam logic [1:0] POS_0 = 2'd0;
	localparam logic [1:0] POS_1 = 2'd1;
	localparam logic [1:0] POS_2 = 2'd2;

	logic [1:0] pos_q;
	logic [3:0] left_q;
	logic [1:0] pos_d;
	logic [3:0] left_d;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		job.chars     = {SlotN{PAD_CHAR}};
		job.last_idx  = 2'd0;
		job.last_flag = 1'b0;
		pos_d         = POS_0;
		left_d        = 4'd0;
		unique case (pos_q)
			POS_1: begin
				job.chars[0] = enc_sextet({left_q[1:0], s_tdata[7:4]});
				if (s_tlast) begin
					job.chars[1]  = enc_sextet({s_tdata[3:0], 2'b00});
					job.last_idx  = 2'd2;
					job.last_flag = 1'b1;
				end else begin
					pos_d  = POS_2;
					left_d = s_tdata[3:0];
				end
			end
			POS_2: begin
				job.chars[0]  = enc_sextet({left_q, s_tdata[7:6]});
				job.chars[1]  = enc_sextet(s_tdata[5:0]);
				job.last_idx  = 2'd1;
				job.last_flag = s_tlast;
			end
			default: begin
				job.chars[0] = enc_sextet(s_tdata[7:2]);
				if (s_tlast) begin
					job.chars[1]  = enc_sextet({s_tdata[1:0], 4'b0000});
					job.last_idx  = 2'd3;
					job.last_flag = 1'b1;
				end else begin
					pos_d  = POS_1;
					left_d = {2'b00, s_tdata[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_0;
			left_q <= 4'd0;
		end else if (push) begin
			pos_q  <= pos_d;
			left_q <= left_d;
		end
	end

endmodule

@@ hw/rtl/b64enc_queue.sv @@
// ----------------------------------------------------------------------------
// b64enc_queue
// short job queue between the byte front end and the character back end
// ----------------------------------------------------------------------------
module b64enc_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64enc_pkg::job_t   push_job,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output b64enc_pkg::job_t   head_job
);
	import b64enc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t            slot_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		r = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_job  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wrap_inc(wr_q);
			end
			if (pop) begin
				rd_q <= wrap_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

@@ hw/rtl/b64enc_back.sv @@
// ----------------------------------------------------------------------------
// b64enc_back
// walks each job and sends its characters one per cycle while m_tready is high and jobs are waiting
// ----------------------------------------------------------------------------
module b64enc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  b64enc_pkg::job_t   head_job,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);
	import b64enc_pkg::*;

	job_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	char_t      out_char_q;
	logic       out_last_q;

	logic adv;
	logic done;

	assign adv  = cur_valid_q && (!out_valid_q || m_tready);
	assign done = adv && (idx_q == cur_q.last_idx);
	assign pop  = q_not_empty && (!cur_valid_q || done);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_job;
		end
		if (adv) begin
			out_char_q <= cur_q.chars[idx_q];
			out_last_q <= done && cur_q.last_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else begin
				if (done) begin
					cur_valid_q <= 1'b0;
				end
				if (adv) begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

endmodule

@@ hw/rtl/base64_stream_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// standard base64 encoder with '=' padding, one byte in, characters out
// ----------------------------------------------------------------------------
// each input item is one message byte, tlast marking the final byte. a byte
// gives one or two characters, a final byte up to four with the padding;
// tlast on the output marks the final character. the output register sends
// one character per cycle while m_tready is high, so a three-byte group gives
// four output characters and throughput is set by that register. bytes are
// taken every cycle while the job queue (QUEUE_DEPTH entries) has room; the
// first character of a taken byte passes the queue, job and output registers.
module base64_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte[7:0]
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_char[6:0], zero[7]
	output logic       m_tlast
);
	import b64enc_pkg::*;

	logic q_full;
	logic push;
	logic pop;
	logic q_not_empty;
	job_t push_job;
	job_t head_job;

	b64enc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	b64enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head_job    (head_job),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

@@ tb/base64_stream_encoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_checker
// watches both streams, predicts the base64 characters of every accepted
// byte and compares each output item against the oldest expected character
// ----------------------------------------------------------------------------
module base64_stream_encoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	output int         mismatch_count,
	output int         chars_pending
);
	import b64enc_pkg::*;

	typedef struct {
		char_t ch;
		logic  fin;
	} enc_char_t;

	enc_char_t  expected_chars[$];
	logic [1:0] group_pos;
	logic [3:0] carry_bits;

	function automatic char_t sextet_char(input logic [5:0] v);
		string abc;
		abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		return char_t'(abc[v]);
	endfunction

	task automatic push_char(input char_t ch, input logic fin);
		enc_char_t e;
		e.ch = ch;
		e.fin = fin;
		expected_chars = {expected_chars, e};
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		case (group_pos)
			2'd1: begin
				push_char(sextet_char({carry_bits[1:0], b[7:4]}), 1'b0);
				if (fin) begin
					push_char(sextet_char({b[3:0], 2'b00}), 1'b0);
					push_char(PAD_CHAR, 1'b1);
					group_pos = 2'd0;
					carry_bits = 4'd0;
				end else begin
					group_pos = 2'd2;
					carry_bits = b[3:0];
				end
			end
			2'd2: begin
				push_char(sextet_char({carry_bits, b[7:6]}), 1'b0);
				push_char(sextet_char(b[5:0]), fin);
				group_pos = 2'd0;
				carry_bits = 4'd0;
			end
			default: begin
				// position code 3 never occurs and counts as the group start
				push_char(sextet_char(b[7:2]), 1'b0);
				if (fin) begin
					push_char(sextet_char({b[1:0], 4'd0}), 1'b0);
					push_char(PAD_CHAR, 1'b0);
					push_char(PAD_CHAR, 1'b1);
					group_pos = 2'd0;
					carry_bits = 4'd0;
				end else begin
					group_pos = 2'd1;
					carry_bits = {2'b00, b[1:0]};
				end
			end
		endcase
	endtask

	task automatic report(input string what);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t ns: error: %s", $time, what);
		end
	endtask

	task automatic check_char();
		enc_char_t e;
		if (expected_chars.size() == 0) begin
			report($sformatf("unexpected character tdata=%h tlast=%b", m_tdata, m_tlast));
		end else begin
			e = expected_chars.pop_front();
			if (m_tdata !== {1'b0, e.ch}) begin
				report($sformatf("out_char expected %h, got %h", {1'b0, e.ch}, m_tdata));
			end
			if (m_tlast !== e.fin) begin
				report($sformatf("last_char expected %b, got %b (char %h)",
					e.fin, m_tlast, e.ch));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_pos = 2'd0;
			carry_bits = 4'd0;
			expected_chars.delete();
			mismatch_count = 0;
			chars_pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_char();
			end
			if (s_tvalid && s_tready) begin
				encode_byte(s_tdata, s_tlast);
			end
			chars_pending = expected_chars.size();
		end
	end

endmodule

@@ tb/tb_base64_stream_encoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder_unit
// drives messages of raw bytes into the encoder under varying idle and stall
// patterns; the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder_unit;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles = 10;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // data_byte[7:0]
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // out_char[6:0], zero[7]
	logic       m_tlast;

	int mismatch_count;
	int chars_pending;
	int send_idle_pct;
	int stall_pct;
	int idle_cycles;

	base64_stream_encoder_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	base64_stream_encoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.chars_pending  (chars_pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_messages(input int n_bytes);
		int sent;
		int len;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(7, 24);
			end else begin
				len = $urandom_range(1, 6);
			end
			for (int i = 0; i < len; i++) begin
				send_byte(8'($urandom_range(0, 255)), i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		idle_cycles = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one, two and three byte messages end at each group position
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// plus signs throughout
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
		// zero bytes across a group boundary, then two mixed-value messages
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h03, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h3F, 1'b0);
		send_byte(8'h0F, 1'b1);

		send_messages(100);
		send_idle_pct = 82;
		send_messages(105);
		send_idle_pct = 0;
		stall_pct = 82;
		send_messages(105);
		send_idle_pct = 38;
		stall_pct = 38;
		send_messages(105);
		send_idle_pct = 0;
		stall_pct = 0;
		send_messages(15);
		s_tvalid <= 1'b0;

		while (chars_pending != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
		if (mismatch_count == 0 && chars_pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/b64enc_pkg.sv
hw/rtl/b64enc_front.sv
hw/rtl/b64enc_queue.sv
hw/rtl/b64enc_back.sv
hw/rtl/base64_stream_encoder_unit.sv
tb/base64_stream_encoder_checker.sv
tb/tb_base64_stream_encoder_unit.sv
